// ----- hw/rtl/swhkd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window hot-key detector package
// Shared widths, register indexes, sequencer states and elaboration helpers.
// ----------------------------------------------------------------------------
package swhkd_pkg;

    localparam int TIME_W       = 32;
    localparam int KEY_W        = 10;
    localparam int THR_W        = 11;
    localparam int COUNT_OUT_W  = 11;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 32;
    localparam int RED_STEP_W   = 4;
    localparam int RED_SUB_W    = 27;

    localparam int KEY_COUNT_DEF    = 1024;
    localparam int WINDOW_DEPTH_DEF = 1024;

    localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = 11'h7FF;
    localparam logic [TIME_W-1:0]      WINDOW_LENGTH_RST = 32'd1;
    localparam logic [THR_W-1:0]       HOT_THRESHOLD_RST = 11'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOT_THRESHOLD = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_FULL_KEY,
        ST_FULL_WR,
        ST_PUSH,
        ST_PUSH_WR,
        ST_HEAD_CHK,
        ST_EVICT_WR,
        ST_FIN_RD,
        ST_FINISH
    } state_t;

    // Highest shift at which the key count still fits below the largest key.
    function automatic int red_top(input int key_count);
        int top;
        top = 0;
        for (int i = 0; i < KEY_W; i++)
        begin
            if ((key_count << i) < (1 << KEY_W))
            begin
                top = i;
            end
        end
        return top;
    endfunction

endpackage

// ----- hw/rtl/sliding_window_hot_key_detector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window hot-key detector
// Counts key events inside a time window and flags keys whose count reaches
// a programmable threshold.
// ----------------------------------------------------------------------------
// Events enter on the s_axis channel, one transfer per event, with
// nondecreasing timestamps. Each event yields exactly one result transfer on
// the m_axis channel carrying the in-window count of its key and its flags.
// The cfg channel writes the window length (index 0) and the hot threshold
// (index 1) and is always ready; it is to be written only while the block is
// idle, as the user must ensure; the block does not enforce it. One sequencer
// drives a single-port window FIFO memory and a per-key count memory, each
// with registered read data, so an event is handled in steps: CHECK, PUSH_WR
// and HEAD_CHK, then FINISH loads the output register. A full FIFO adds
// FULL_KEY, FULL_WR and PUSH, each evicted event adds EVICT_WR and HEAD_CHK
// (FIN_RD once the FIFO is empty), a KEY_COUNT below 1024 that is not a power
// of two adds REDUCE steps first, and an out-of-order event goes from CHECK
// to FINISH. The output register parts each event from the next, so a new
// event is taken while a result waits. If the receiver stalls, the next result
// holds in the sequencer until the output register is free. After reset the
// count memory is cleared, one key per cycle, while s_axis_tready stays low.
// ----------------------------------------------------------------------------
module sliding_window_hot_key_detector_unit #(
    parameter int KEY_COUNT    = swhkd_pkg::KEY_COUNT_DEF,
    parameter int WINDOW_DEPTH = swhkd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Fields from bit 0 up: event_time[31:0], event_key[41:32], zero fill.
    input  logic [swhkd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: window_count[10:0], is_hot[11], newly_hot[12],
    // order_error[13], overflow[14], zero fill.
    output logic [swhkd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swhkd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swhkd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TW   = swhkd_pkg::TIME_W;
    localparam int KW   = swhkd_pkg::KEY_W;
    localparam int KIW  = $clog2(KEY_COUNT);
    localparam int WIW  = $clog2(WINDOW_DEPTH);
    localparam int OW   = $clog2(WINDOW_DEPTH + 1);
    localparam int CW   = OW;
    localparam int CEW  = CW + 1;
    localparam int FEW  = KIW + TW;
    localparam int CMPW = (CW > swhkd_pkg::THR_W) ? CW : swhkd_pkg::THR_W;
    localparam int RSW  = swhkd_pkg::RED_STEP_W;
    localparam int SUBW = swhkd_pkg::RED_SUB_W;
    localparam bit KEY_DIRECT = ((KEY_COUNT & (KEY_COUNT - 1)) == 0) ||
                                (KEY_COUNT >= (1 << KW));
    localparam int RED_TOP = swhkd_pkg::red_top(KEY_COUNT);

    swhkd_pkg::state_t state_reg, state_next;

    logic [TW-1:0]     wl_reg;
    logic [swhkd_pkg::THR_W-1:0] thr_reg;

    logic [KIW-1:0]    clr_reg, clr_next;
    logic [TW-1:0]     time_reg, time_next;
    logic [KIW-1:0]    key_reg, key_next;
    logic [KW-1:0]     rem_reg, rem_next;
    logic [RSW-1:0]    step_reg, step_next;
    logic [TW-1:0]     last_reg, last_next;
    logic [WIW-1:0]    head_reg, head_next;
    logic [WIW-1:0]    tail_reg, tail_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic              ovf_reg, ovf_next;
    logic              oerr_reg, oerr_next;

    logic [swhkd_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic              out_hot_reg, out_hot_next;
    logic              out_newly_reg, out_newly_next;
    logic              out_oerr_reg, out_oerr_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_valid_reg, out_valid_next;

    logic [FEW-1:0]    fifo_mem [WINDOW_DEPTH];
    logic [FEW-1:0]    fifo_q_reg;
    logic              fifo_re;
    logic [WIW-1:0]    fifo_raddr;
    logic              fifo_we;
    logic [WIW-1:0]    fifo_waddr;
    logic [FEW-1:0]    fifo_wdata;

    logic [CEW-1:0]    cnt_mem [KEY_COUNT];
    logic [CEW-1:0]    cnt_q_reg;
    logic              cnt_re;
    logic [KIW-1:0]    cnt_raddr;
    logic              cnt_we;
    logic [KIW-1:0]    cnt_waddr;
    logic [CEW-1:0]    cnt_wdata;

    logic [KIW-1:0]    ev_key;
    logic [TW-1:0]     ev_time;
    logic [TW-1:0]     ev_age;
    logic              ev_due;
    logic [CW-1:0]     q_count;
    logic              q_hot;
    logic [CW-1:0]     q_count_dec;
    logic [WIW-1:0]    head_inc;
    logic [WIW-1:0]    tail_inc;
    logic              fifo_full;
    logic [SUBW-1:0]   red_sub;
    logic [KW-1:0]     rem_step;
    logic              reaches_thr;
    logic              out_free;

    assign ev_key      = fifo_q_reg[FEW-1:TW];
    assign ev_time     = fifo_q_reg[TW-1:0];
    assign ev_age      = time_reg - ev_time;
    assign ev_due      = (ev_age >= wl_reg);
    assign q_count     = cnt_q_reg[CW-1:0];
    assign q_hot       = cnt_q_reg[CW];
    assign q_count_dec = (q_count != '0) ? (q_count - 1'b1) : '0;
    assign head_inc    = (head_reg == WIW'(WINDOW_DEPTH - 1)) ? '0 : (head_reg + 1'b1);
    assign tail_inc    = (tail_reg == WIW'(WINDOW_DEPTH - 1)) ? '0 : (tail_reg + 1'b1);
    assign fifo_full   = (occ_reg == OW'(WINDOW_DEPTH));
    assign red_sub     = SUBW'(KEY_COUNT) << step_reg;
    assign rem_step    = (SUBW'(rem_reg) >= red_sub) ? (rem_reg - KW'(red_sub)) : rem_reg;
    assign reaches_thr = (CMPW'(q_count) >= CMPW'(thr_reg));
    assign out_free    = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == swhkd_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_ovf_reg, out_oerr_reg, out_newly_reg,
                            out_hot_reg, out_count_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        time_next      = time_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        ovf_next       = ovf_reg;
        oerr_next      = oerr_reg;
        out_count_next = out_count_reg;
        out_hot_next   = out_hot_reg;
        out_newly_next = out_newly_reg;
        out_oerr_next  = out_oerr_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        fifo_re        = 1'b0;
        fifo_raddr     = head_reg;
        fifo_we        = 1'b0;
        fifo_waddr     = tail_reg;
        fifo_wdata     = {key_reg, time_reg};
        cnt_re         = 1'b0;
        cnt_raddr      = key_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = key_reg;
        cnt_wdata      = '0;

        unique case (state_reg)
            swhkd_pkg::ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                if (clr_reg == KIW'(KEY_COUNT - 1))
                begin
                    state_next = swhkd_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            swhkd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    time_next  = s_axis_tdata[TW-1:0];
                    rem_next   = s_axis_tdata[TW+KW-1:TW];
                    key_next   = KIW'(s_axis_tdata[TW+KW-1:TW]);
                    step_next  = RSW'(RED_TOP);
                    ovf_next   = 1'b0;
                    oerr_next  = 1'b0;
                    state_next = KEY_DIRECT ? swhkd_pkg::ST_CHECK : swhkd_pkg::ST_REDUCE;
                end
            end
            swhkd_pkg::ST_REDUCE:
            begin
                rem_next = rem_step;
                if (step_reg == '0)
                begin
                    key_next   = KIW'(rem_step);
                    state_next = swhkd_pkg::ST_CHECK;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            swhkd_pkg::ST_CHECK:
            begin
                if (time_reg < last_reg)
                begin
                    oerr_next  = 1'b1;
                    cnt_re     = 1'b1;
                    state_next = swhkd_pkg::ST_FINISH;
                end
                else
                begin
                    last_next = time_reg;
                    if (fifo_full)
                    begin
                        fifo_re    = 1'b1;
                        state_next = swhkd_pkg::ST_FULL_KEY;
                    end
                    else
                    begin
                        fifo_we    = 1'b1;
                        tail_next  = tail_inc;
                        occ_next   = occ_reg + 1'b1;
                        cnt_re     = 1'b1;
                        state_next = swhkd_pkg::ST_PUSH_WR;
                    end
                end
            end
            swhkd_pkg::ST_FULL_KEY:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = ev_key;
                state_next = swhkd_pkg::ST_FULL_WR;
            end
            swhkd_pkg::ST_FULL_WR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = ev_key;
                cnt_wdata  = {q_hot, q_count_dec};
                head_next  = head_inc;
                occ_next   = occ_reg - 1'b1;
                ovf_next   = 1'b1;
                state_next = swhkd_pkg::ST_PUSH;
            end
            swhkd_pkg::ST_PUSH:
            begin
                fifo_we    = 1'b1;
                tail_next  = tail_inc;
                occ_next   = occ_reg + 1'b1;
                cnt_re     = 1'b1;
                state_next = swhkd_pkg::ST_PUSH_WR;
            end
            swhkd_pkg::ST_PUSH_WR:
            begin
                cnt_we     = 1'b1;
                cnt_wdata  = {q_hot, q_count + 1'b1};
                fifo_re    = 1'b1;
                state_next = swhkd_pkg::ST_HEAD_CHK;
            end
            swhkd_pkg::ST_HEAD_CHK:
            begin
                cnt_re = 1'b1;
                if (ev_due)
                begin
                    cnt_raddr  = ev_key;
                    state_next = swhkd_pkg::ST_EVICT_WR;
                end
                else
                begin
                    state_next = swhkd_pkg::ST_FINISH;
                end
            end
            swhkd_pkg::ST_EVICT_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = ev_key;
                cnt_wdata = {q_hot, q_count_dec};
                head_next = head_inc;
                occ_next  = occ_reg - 1'b1;
                if (occ_reg == OW'(1))
                begin
                    state_next = swhkd_pkg::ST_FIN_RD;
                end
                else
                begin
                    fifo_re    = 1'b1;
                    fifo_raddr = head_inc;
                    state_next = swhkd_pkg::ST_HEAD_CHK;
                end
            end
            swhkd_pkg::ST_FIN_RD:
            begin
                cnt_re     = 1'b1;
                state_next = swhkd_pkg::ST_FINISH;
            end
            swhkd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_count_next = (CMPW'(q_count) > CMPW'(swhkd_pkg::COUNT_OUT_MAX)) ?
                                     swhkd_pkg::COUNT_OUT_MAX :
                                     swhkd_pkg::COUNT_OUT_W'(q_count);
                    out_hot_next   = q_hot;
                    out_newly_next = 1'b0;
                    out_oerr_next  = oerr_reg;
                    out_ovf_next   = ovf_reg;
                    out_valid_next = 1'b1;
                    if (!oerr_reg && reaches_thr && !q_hot)
                    begin
                        cnt_we         = 1'b1;
                        cnt_wdata      = {1'b1, q_count};
                        out_hot_next   = 1'b1;
                        out_newly_next = 1'b1;
                    end
                    state_next = swhkd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swhkd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swhkd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            last_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            ovf_reg       <= 1'b0;
            oerr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            last_reg      <= last_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            ovf_reg       <= ovf_next;
            oerr_reg      <= oerr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg  <= swhkd_pkg::WINDOW_LENGTH_RST;
            thr_reg <= swhkd_pkg::HOT_THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                swhkd_pkg::CFG_WINDOW_LENGTH: wl_reg  <= cfg_data;
                swhkd_pkg::CFG_HOT_THRESHOLD: thr_reg <= cfg_data[swhkd_pkg::THR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg      <= time_next;
        key_reg       <= key_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        out_count_reg <= out_count_next;
        out_hot_reg   <= out_hot_next;
        out_newly_reg <= out_newly_next;
        out_oerr_reg  <= out_oerr_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        if (fifo_re)
        begin
            fifo_q_reg <= fifo_mem[fifo_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_q_reg <= cnt_mem[cnt_raddr];
        end
    end

endmodule

// ----- tb/hot_key_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot-key detector result checker
// Watches the configuration, event and result channels of the detector,
// keeps its own copy of the window FIFO, per-key counts and hot marks, and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hot_key_checker
    import swhkd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     reports_due,
    output int                     report_count,
    output int                     overflow_count,
    output int                     order_error_count,
    output int                     newly_hot_count
);

    localparam int KEY_SLOTS  = KEY_COUNT_DEF;
    localparam int FIFO_SLOTS = WINDOW_DEPTH_DEF;

    typedef struct packed {
        logic                   overflow;
        logic                   order_error;
        logic                   newly_hot;
        logic                   is_hot;
        logic [COUNT_OUT_W-1:0] window_count;
    } key_report_t;

    logic [TIME_W-1:0] win_len;
    logic [THR_W-1:0]  hot_thr;
    logic [TIME_W-1:0] fifo_stamp [FIFO_SLOTS];
    logic [KEY_W-1:0]  fifo_key [FIFO_SLOTS];
    int                head_ptr;
    int                tail_ptr;
    int                fill;
    int                key_tally [KEY_SLOTS];
    bit                hot_mark [KEY_SLOTS];
    logic [TIME_W-1:0] newest_stamp;
    key_report_t       awaited_reports [$];
    key_report_t       want_r;
    key_report_t       got_r;

    function automatic logic [COUNT_OUT_W-1:0] clip_count(input int c);
        if (c > int'(COUNT_OUT_MAX))
        begin
            return COUNT_OUT_MAX;
        end
        return c[COUNT_OUT_W-1:0];
    endfunction

    function automatic void drop_oldest();
        int k;
        k = int'(fifo_key[head_ptr]) % KEY_SLOTS;
        if (key_tally[k] > 0)
        begin
            key_tally[k]--;
        end
        head_ptr = (head_ptr + 1) % FIFO_SLOTS;
        fill--;
    endfunction

    function automatic key_report_t apply_key_event(input logic [TIME_W-1:0] stamp,
                                                    input logic [KEY_W-1:0]  key);
        key_report_t r;
        int          k;
        k = int'(key) % KEY_SLOTS;
        r = '0;
        if (stamp < newest_stamp)
        begin
            r.window_count = clip_count(key_tally[k]);
            r.is_hot       = hot_mark[k];
            r.order_error  = 1'b1;
            return r;
        end
        newest_stamp = stamp;
        if (fill >= FIFO_SLOTS)
        begin
            drop_oldest();
            r.overflow = 1'b1;
        end
        fifo_stamp[tail_ptr] = stamp;
        fifo_key[tail_ptr]   = key;
        tail_ptr = (tail_ptr + 1) % FIFO_SLOTS;
        fill++;
        key_tally[k]++;
        while (fill > 0 && (stamp - fifo_stamp[head_ptr]) >= win_len)
        begin
            drop_oldest();
        end
        if (key_tally[k] >= int'(hot_thr) && !hot_mark[k])
        begin
            hot_mark[k] = 1'b1;
            r.newly_hot = 1'b1;
        end
        r.window_count = clip_count(key_tally[k]);
        r.is_hot       = hot_mark[k];
        return r;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len      = WINDOW_LENGTH_RST;
            hot_thr      = HOT_THRESHOLD_RST;
            head_ptr     = 0;
            tail_ptr     = 0;
            fill         = 0;
            newest_stamp = '0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                key_tally[i] = 0;
                hot_mark[i]  = 1'b0;
            end
            awaited_reports.delete();
            fail_count        = 0;
            reports_due       = 0;
            report_count      = 0;
            overflow_count    = 0;
            order_error_count = 0;
            newly_hot_count   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WINDOW_LENGTH)
                begin
                    win_len = cfg_data[TIME_W-1:0];
                end
                else if (cfg_index == CFG_HOT_THRESHOLD)
                begin
                    hot_thr = cfg_data[THR_W-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want_r = apply_key_event(s_axis_tdata[TIME_W-1:0],
                                         s_axis_tdata[TIME_W +: KEY_W]);
                overflow_count    += int'(want_r.overflow);
                order_error_count += int'(want_r.order_error);
                newly_hot_count   += int'(want_r.newly_hot);
                awaited_reports.push_back(want_r);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r = m_axis_tdata[$bits(key_report_t)-1:0];
                if (awaited_reports.size() == 0)
                begin
                    $error("Result transfer with no event outstanding: tdata 0x%h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want_r = awaited_reports.pop_front();
                    report_count++;
                    check_field("window_count", int'(want_r.window_count),
                                int'(got_r.window_count));
                    check_field("is_hot", int'(want_r.is_hot), int'(got_r.is_hot));
                    check_field("newly_hot", int'(want_r.newly_hot), int'(got_r.newly_hot));
                    check_field("order_error", int'(want_r.order_error),
                                int'(got_r.order_error));
                    check_field("overflow", int'(want_r.overflow), int'(got_r.overflow));
                end
            end
            reports_due = awaited_reports.size();
        end
    end

endmodule

// ----- tb/sliding_window_hot_key_detector_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window hot-key detector testbench
// Drives timestamped key events through directed cases and randomized runs
// that fill and overflow the window FIFO, under varying back-pressure, and
// reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module sliding_window_hot_key_detector_unit_tb;
    import swhkd_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_WINDOW_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic [TIME_W-1:0] stream_time = '0;

    int fail_count;
    int reports_due;
    int report_count;
    int overflow_count;
    int order_error_count;
    int newly_hot_count;

    sliding_window_hot_key_detector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    hot_key_checker report_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .reports_due       (reports_due),
        .report_count      (report_count),
        .overflow_count    (overflow_count),
        .order_error_count (order_error_count),
        .newly_hot_count   (newly_hot_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] win,
                             input logic [CFG_DATA_W-1:0] thr);
        s_axis_tvalid = 1'b0;
        while (reports_due != 0)
        begin
            @(negedge clk);
        end
        write_reg(CFG_WINDOW_LENGTH, win);
        write_reg(CFG_HOT_THRESHOLD, thr);
        cfg_valid = 1'b0;
    endtask

    task automatic send_event(input logic [TIME_W-1:0] stamp, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {{(IN_TDATA_W-TIME_W-KEY_W){1'b0}}, key, stamp};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (stamp > stream_time)
        begin
            stream_time = stamp;
        end
    endtask

    // Half of the events go to a few favored keys so that counts climb to the
    // threshold; the rest spread over the whole key range.
    task automatic random_phase(input int count, input int hot_keys, input int max_step,
                                input int err_pct, input int jump_pct);
        logic [KEY_W-1:0]  favored [8];
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
        int                step;
        for (int i = 0; i < 8; i++)
        begin
            favored[i] = $urandom_range((1 << KEY_W) - 1);
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(1) == 1)
            begin
                key = favored[$urandom_range(hot_keys - 1)];
            end
            else
            begin
                key = $urandom_range((1 << KEY_W) - 1);
            end
            if (stream_time != 0 && $urandom_range(99) < err_pct)
            begin
                stamp = stream_time - $urandom_range(stream_time, 1);
            end
            else
            begin
                if ($urandom_range(99) < jump_pct)
                begin
                    step = $urandom_range(1 << 24);
                end
                else
                begin
                    step = $urandom_range(max_step);
                end
                stamp = stream_time + step;
            end
            send_event(stamp, key);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (!s_axis_tready)
        begin
            @(negedge clk);
        end

        send_idle_pct = 8;
        recv_idle_pct = 80;

        // Zero window empties the FIFO on every event; zero threshold marks
        // every accepted key hot.
        configure(32'd0, 32'd0);
        send_event(32'd0, 10'd0);
        send_event(32'd0, 10'd1023);
        send_event(32'd0, 10'd0);

        configure(32'd4, 32'd2);
        send_event(32'd10, 10'd5);
        send_event(32'd11, 10'd5);
        send_event(32'd12, 10'd5);
        send_event(32'd5, 10'd5);
        send_event(32'd13, 10'd1023);
        send_event(32'd14, 10'd5);
        send_event(32'd14, 10'd0);
        send_event(32'd20, 10'd5);
        send_event(32'd0, 10'd1023);

        configure(32'd1, 32'hFFFF_FFFF);
        send_event(32'd21, 10'h2AA);
        send_event(32'd21, 10'h155);
        send_event(32'd22, 10'h2AA);

        // An endless window lets the FIFO fill up and overflow.
        configure(32'hFFFF_FFFF, $urandom_range(40, 2));
        random_phase(500, 8, 3, 2, 0);

        send_idle_pct = 80;
        recv_idle_pct = 8;
        configure(32'hFFFF_FFFF, $urandom_range(90, 40));
        random_phase(580, 3, 3, 2, 0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure($urandom_range(64, 1), $urandom_range(6, 1));
        random_phase(100, 4, 8, 5, 5);

        configure(32'd0, 32'd3);
        random_phase(3, 2, 2, 0, 0);

        configure(32'hFFFF_FFFF, 32'd1);
        send_event(32'hFFFF_FFFE, 10'd1023);
        send_event(32'hFFFF_FFFF, 10'd0);
        send_event(32'hFFFF_FFFF, 10'd1023);
        send_event(32'h8000_0000, 10'd7);
        s_axis_tvalid = 1'b0;

        while (reports_due != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        $display("Checked %0d results: %0d out of order, %0d FIFO overflows, %0d keys turned hot.",
                 report_count, order_error_count, overflow_count, newly_hot_count);
        $display("Window lengths ran from zero to all ones, thresholds from zero to 2047.");
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sliding_window_hot_key_detector_unit.f -----
hw/rtl/swhkd_pkg.sv
hw/rtl/sliding_window_hot_key_detector_unit.sv
tb/hot_key_checker.sv
tb/sliding_window_hot_key_detector_unit_tb.sv
